// ===== src/clti_pkg.sv =====
// Shared types and constants for the clamped linear table interpolator.
// No dependencies; clti_front, clti_back, the top and the bench import it.
`default_nettype none

package clti_pkg;

    // Operation codes carried in the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // Region codes of a result.
    localparam logic [1:0] REGION_INTERP = 2'd0;
    localparam logic [1:0] REGION_LOW    = 2'd1;
    localparam logic [1:0] REGION_HIGH   = 2'd2;

    localparam int          VALUE_W        = 32;
    localparam int          RESULT_LIMIT   = 32;
    localparam int          CMD_FIFO_DEPTH = 4;
    localparam int          OUT_FIFO_DEPTH = 4;
    localparam logic [16:0] ONE_Q16        = 17'h10000;

    // One classified command between front and back.
    typedef struct packed {
        logic              is_query;
        logic [7:0]        row;
        logic [4:0]        col;
        logic [VALUE_W-1:0] data;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [4:0]         col;
        logic [VALUE_W-1:0] value;
        logic [1:0]         region;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// ===== src/clti_fifo.sv =====
// Small synchronous FIFO used for the command queue and the result queue.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module clti_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             push_data,
    output logic                              full,
    input  wire logic                         pop,
    output logic                              out_valid,
    output logic [WIDTH-1:0]                  out_data,
    output logic [$clog2(DEPTH+1)-1:0]        count
);
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/clti_front.sv =====
// Input stage: accepts beats, drops out-of-range writes and forms commands.
// Depends on clti_pkg.
`default_nettype none

module clti_front
    import clti_pkg::*;
#(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tuser,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  wire logic        cmd_ready
);
    logic hold_v_reg, hold_v_next;
    cmd_t cmd_reg;
    cmd_t cmd_new;
    logic accept;
    logic keep;

    assign s_tready  = !hold_v_reg || cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign cmd_valid = hold_v_reg;
    assign cmd       = cmd_reg;

    // Classify the beat: queries always pass, writes only inside the table.
    always_comb
    begin
        cmd_new.is_query = (s_tuser == OP_QUERY);
        cmd_new.row      = s_tdata[7:0];
        cmd_new.col      = s_tdata[12:8];
        cmd_new.data     = cmd_new.is_query ? s_tdata[76:45] : s_tdata[44:13];
        keep = cmd_new.is_query ||
               ((32'(cmd_new.row) < MAX_ROWS) && (32'(cmd_new.col) < MAX_COLUMNS));
    end

    always_comb
    begin
        hold_v_next = hold_v_reg;
        if (cmd_ready)
        begin
            hold_v_next = 1'b0;
        end
        if (accept && keep)
        begin
            hold_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg <= cmd_new;
        end
    end

endmodule

`default_nettype wire

// ===== src/clti_div.sv =====
// Restoring divider for the Q1.16 blend weight, one quotient bit per cycle.
// Depends on nothing; the caller guarantees dividend <= divisor, divisor > 0.
`default_nettype none

module clti_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [16:0]      quotient
);
    logic [32:0] rem_reg, rem_next;
    logic [31:0] d_reg;
    logic [16:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic        ge;
    logic [32:0] diff;
    logic [32:0] rem_kept;

    assign done     = done_reg;
    assign quotient = q_reg;

    // One step of (dividend << 16) / divisor.
    always_comb
    begin
        ge        = (rem_reg >= {1'b0, d_reg});
        diff      = rem_reg - {1'b0, d_reg};
        rem_kept  = ge ? diff : rem_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {1'b0, dividend};
            cnt_next = 5'd17;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = {rem_kept[31:0], 1'b0};
            q_next   = {q_reg[15:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 5'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

// ===== src/clti_back.sv =====
// Execution side: table memory, binary search, weight division and blend pipeline.
// Depends on clti_pkg and clti_div.
`default_nettype none

module clti_back
    import clti_pkg::*;
#(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wen,
    input  wire logic                                  cfg_index,
    input  wire logic [8:0]                            cfg_data,
    input  wire logic                                  cmd_valid,
    input  cmd_t                                       cmd,
    output logic                                       cmd_ready,
    output logic                                       res_valid,
    output res_t                                       res,
    input  wire logic [$clog2(OUT_FIFO_DEPTH+1)-1:0]   res_count
);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int COL_LIMIT = (MAX_COLUMNS < RESULT_LIMIT) ? MAX_COLUMNS : RESULT_LIMIT;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRD  = 3'd1;
    localparam logic [2:0] ST_SCMP = 3'd2;
    localparam logic [2:0] ST_SEL  = 3'd3;
    localparam logic [2:0] ST_POS  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [8:0]          row_count_reg;
    logic [5:0]          column_count_reg;
    logic [CNT_W-1:0]    rows_eff;
    logic [5:0]          cols_eff;
    logic [CNT_W-1:0]    rows_reg, rows_next;
    logic [5:0]          cols_reg, cols_next;
    logic [CNT_W-1:0]    lo_reg, lo_next, n_reg, n_next;
    logic [CNT_W-1:0]    half, mid;
    logic signed [31:0]  x_reg, x_next;
    logic [4:0]          c_reg, c_next;
    logic [1:0]          region_reg, region_next;
    logic [ROW_W-1:0]    left_reg, left_next, right_reg, right_next;
    logic [16:0]         wl_reg, wl_next, wr_reg, wr_next;

    logic [VALUE_W-1:0]  mem [MAX_ROWS * (2 ** COL_W)];
    logic [ADDR_W-1:0]   addr_a, addr_b, waddr;
    logic                mem_we;
    logic [VALUE_W-1:0]  rd_a_reg, rd_b_reg;

    logic                issue, col_last;
    logic                v_rd_reg, v_mul_reg;
    res_t                tag_rd_reg, tag_mul_reg, tag_issue;
    logic signed [49:0]  prod_a_reg, prod_b_reg;
    logic signed [50:0]  sum;
    logic signed [34:0]  shifted;
    logic [VALUE_W-1:0]  sat_value;

    logic                div_start, div_done;
    logic [16:0]         div_q;
    logic [32:0]         dist_x, dist_r;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 9'd1;
            column_count_reg <= 6'd32;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else
            begin
                column_count_reg <= cfg_data[5:0];
            end
        end
    end

    // Effective row and column counts after clamping.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = CNT_W'(1);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            rows_eff = CNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = CNT_W'(row_count_reg);
        end
        if (column_count_reg == '0)
        begin
            cols_eff = 6'd1;
        end
        else if (32'(column_count_reg) > COL_LIMIT)
        begin
            cols_eff = 6'(COL_LIMIT);
        end
        else
        begin
            cols_eff = column_count_reg;
        end
    end

    assign half      = n_reg >> 1;
    assign mid       = lo_reg + half;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign col_last  = (({1'b0, c_reg} + 6'd1) == cols_reg);
    assign issue     = (state_reg == ST_EMIT) &&
                       ((int'(res_count) + int'(v_rd_reg) + int'(v_mul_reg)) < OUT_FIFO_DEPTH);
    assign div_start = (state_reg == ST_POS);
    assign dist_x    = {x_reg[31], x_reg} - {rd_a_reg[31], rd_a_reg};
    assign dist_r    = {rd_b_reg[31], rd_b_reg} - {rd_a_reg[31], rd_a_reg};
    assign mem_we    = (state_reg == ST_IDLE) && cmd_valid && !cmd.is_query;
    assign waddr     = {ROW_W'(cmd.row), COL_W'(cmd.col)};

    // Sequencer: search, weight, then one column per cycle while credit lasts.
    always_comb
    begin
        state_next  = state_reg;
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        lo_next     = lo_reg;
        n_next      = n_reg;
        x_next      = x_reg;
        c_next      = c_reg;
        region_next = region_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        wl_next     = wl_reg;
        wr_next     = wr_reg;
        addr_a      = '0;
        addr_b      = '0;
        tag_issue.col    = c_reg;
        tag_issue.value  = '0;
        tag_issue.region = region_reg;
        tag_issue.last   = col_last;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_query)
                begin
                    x_next     = cmd.data;
                    rows_next  = rows_eff;
                    cols_next  = cols_eff;
                    lo_next    = '0;
                    n_next     = rows_eff;
                    c_next     = '0;
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                addr_a     = {ROW_W'(mid), COL_W'(0)};
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                if ($signed(rd_a_reg) < x_reg)
                begin
                    lo_next = mid + 1'b1;
                    n_next  = n_reg - half - 1'b1;
                end
                else
                begin
                    n_next = half;
                end
                state_next = (n_next == '0) ? ST_SEL : ST_SRD;
            end
            ST_SEL:
            begin
                wl_next = ONE_Q16;
                wr_next = '0;
                if (lo_reg >= rows_reg)
                begin
                    region_next = REGION_HIGH;
                    left_next   = ROW_W'(rows_reg - 1'b1);
                    right_next  = ROW_W'(rows_reg - 1'b1);
                    state_next  = ST_EMIT;
                end
                else if (lo_reg == '0)
                begin
                    region_next = REGION_LOW;
                    left_next   = '0;
                    right_next  = '0;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    region_next = REGION_INTERP;
                    left_next   = ROW_W'(lo_reg - 1'b1);
                    right_next  = ROW_W'(lo_reg);
                    addr_a      = {ROW_W'(lo_reg - 1'b1), COL_W'(0)};
                    addr_b      = {ROW_W'(lo_reg), COL_W'(0)};
                    state_next  = ST_POS;
                end
            end
            ST_POS:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr_next    = div_q;
                    wl_next    = ONE_Q16 - div_q;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                addr_a = {left_reg, COL_W'(c_reg)};
                addr_b = {right_reg, COL_W'(c_reg)};
                if (issue)
                begin
                    c_next = c_reg + 1'b1;
                    if (col_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v_rd_reg  <= 1'b0;
            v_mul_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_rd_reg  <= issue;
            v_mul_reg <= v_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg    <= rows_next;
        cols_reg    <= cols_next;
        lo_reg      <= lo_next;
        n_reg       <= n_next;
        x_reg       <= x_next;
        c_reg       <= c_next;
        region_reg  <= region_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        wl_reg      <= wl_next;
        wr_reg      <= wr_next;
        tag_rd_reg  <= tag_issue;
        tag_mul_reg <= tag_rd_reg;
        prod_a_reg  <= $signed({1'b0, wl_reg}) * $signed(rd_a_reg);
        prod_b_reg  <= $signed({1'b0, wr_reg}) * $signed(rd_b_reg);
    end

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd.data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    clti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dist_x[31:0]),
        .divisor  (dist_r[31:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Round half up, drop the fraction and saturate to 32 bits.
    always_comb
    begin
        sum     = {prod_a_reg[49], prod_a_reg} + {prod_b_reg[49], prod_b_reg}
                  + 51'sd32768;
        shifted = sum[50:16];
        if (shifted > 35'sh07FFFFFFF)
        begin
            sat_value = 32'h7FFFFFFF;
        end
        else if (shifted < -35'sh080000000)
        begin
            sat_value = 32'h80000000;
        end
        else
        begin
            sat_value = shifted[31:0];
        end
        res        = tag_mul_reg;
        res.value  = sat_value;
    end

    assign res_valid = v_mul_reg;

endmodule

`default_nettype wire

// ===== src/clamped_linear_table_interpolator.sv =====
// Top level of the clamped linear table interpolator: front, queues and back.
// Depends on clti_pkg, clti_front, clti_fifo and clti_back.
//
// Channel    Handshake           Contents
// s_*        tvalid/tready       tuser operation; tdata row, column, element, position
// m_*        tvalid/tready       tuser region; tdata column, value; tlast final column
// cfg_*      cfg_wen             cfg_index register, cfg_data value
//
// A write is stored by the back while it is idle. A query is taken while idle, then runs the
// binary search, a select step, then a position step and the weight division when interpolating,
// then one column per cycle while the result queue has room, via read and product registers.
// Reset clears control state only; the table holds garbage until written.
// A four-beat result queue and a four-command queue let either side stall alone.
`default_nettype none

module clamped_linear_table_interpolator
    import clti_pkg::*;
#(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // row_index, column_index, element_value, query_position
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_column, out_value
    output logic [1:0]       m_tuser,   // region
    output logic             m_tlast,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);
    localparam int OCNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    logic                    front_valid, cmd_full, cmd_push;
    cmd_t                    front_cmd, q_cmd;
    logic                    q_valid, q_pop, back_ready;
    logic [$clog2(CMD_FIFO_DEPTH+1)-1:0] q_count;
    logic                    res_push, res_full, res_pop;
    res_t                    res_in, res_out;
    logic [OCNT_W-1:0]       res_count;

    assign cmd_push = front_valid && !cmd_full;

    clti_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (!cmd_full)
    );

    clti_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_cmd),
        .count     (q_count)
    );

    // The back takes a command only when one is waiting.
    assign q_pop = back_ready && q_valid;

    clti_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (back_ready),
        .res_valid (res_push),
        .res       (res_in),
        .res_count (res_count)
    );

    assign res_pop = m_tvalid && m_tready;

    clti_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (res_pop),
        .out_valid (m_tvalid),
        .out_data  (res_out),
        .count     (res_count)
    );

    assign m_tdata = {3'b000, res_out.value, res_out.col};
    assign m_tuser = res_out.region;
    assign m_tlast = res_out.last;

    // The back must never pop an empty queue or push into a full result queue.
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && q_count != '0))
        else $error("command queue popped while empty");

    a_last_region: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_in.region != 2'd3))
        else $error("invalid region on result");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the clamped linear table interpolator.
// Depends on clti_pkg and clamped_linear_table_interpolator; loads tables, queries
// positions and checks every result beat against an in-bench prediction.
`default_nettype none

module tb_top;
    import clti_pkg::*;

    // One expected or observed result beat.
    typedef struct {
        logic [4:0]  col;
        logic [31:0] value;
        logic [1:0]  region;
        logic        last;
    } beat_t;

    // Table mirror, register copies and the queue of expected result beats.
    class clti_scoreboard;
        logic signed [31:0] tbl [256][32];
        int unsigned        row_reg;
        int unsigned        col_reg;
        beat_t              expected_q[$];
        int                 errors;

        function new();
            row_reg = 1;
            col_reg = 32;
            errors  = 0;
        endfunction

        function void set_register(logic idx, int unsigned data);
            if (idx == CFG_ROW_COUNT)
                row_reg = data & 9'h1FF;
            else
                col_reg = data & 6'h3F;
        endfunction

        // Applies a write, or predicts every column beat of a query.
        function void note_input(logic op, logic [7:0] row, logic [4:0] col,
                                 logic signed [31:0] val, logic signed [31:0] pos);
            int unsigned        nrows, ncols, lo, n, half, mid, src;
            logic [1:0]         reg_code;
            longint unsigned    span, num, wr, wl;
            longint             acc;
            beat_t              b;
            if (op == OP_WRITE)
            begin
                tbl[row][col] = val;
                return;
            end
            nrows = (row_reg == 0) ? 1 : (row_reg > 256) ? 256 : row_reg;
            ncols = (col_reg == 0) ? 1 : (col_reg > 32) ? 32 : col_reg;
            // Lower-bound search for the first row not below the query.
            lo = 0;
            n  = nrows;
            while (n > 0)
            begin
                half = n / 2;
                mid  = lo + half;
                if (tbl[mid][0] < pos)
                begin
                    lo = mid + 1;
                    n  = n - half - 1;
                end
                else
                    n = half;
            end
            wr = 0;
            wl = 0;
            if (lo >= nrows)
            begin
                reg_code = REGION_HIGH;
                src      = nrows - 1;
            end
            else if (lo == 0)
            begin
                reg_code = REGION_LOW;
                src      = 0;
            end
            else
            begin
                reg_code = REGION_INTERP;
                src      = lo;
                span = longint'(tbl[lo][0]) - longint'(tbl[lo-1][0]);
                num  = (longint'(pos) - longint'(tbl[lo-1][0])) << 16;
                wr   = (span != 0) ? num / span : 65536;
                if (wr > 65536)
                    wr = 65536;
                wl = 65536 - wr;
            end
            for (int c = 0; c < ncols; c++)
            begin
                if (reg_code == REGION_INTERP)
                    acc = longint'(wl) * longint'(tbl[src-1][c])
                        + longint'(wr) * longint'(tbl[src][c]) + 32768;
                else
                    acc = 65536 * longint'(tbl[src][c]) + 32768;
                acc = acc >>> 16;
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                b.col    = 5'(c);
                b.value  = acc[31:0];
                b.region = reg_code;
                b.last   = (c + 1 == ncols);
                expected_q.insert(expected_q.size(), b);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compares one accepted result beat with the oldest expectation.
        task check_beat(beat_t got);
            beat_t exp_b;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected beat col %0d value %h", got.col, got.value));
                return;
            end
            exp_b = expected_q.pop_front();
            if (got.col !== exp_b.col)
                report($sformatf("column %0d, expected %0d", got.col, exp_b.col));
            if (got.value !== exp_b.value)
                report($sformatf("col %0d value %h, expected %h",
                                 exp_b.col, got.value, exp_b.value));
            if (got.region !== exp_b.region)
                report($sformatf("col %0d region %0d, expected %0d",
                                 exp_b.col, got.region, exp_b.region));
            if (got.last !== exp_b.last)
                report($sformatf("col %0d last %0d, expected %0d",
                                 exp_b.col, got.last, exp_b.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // row_index, column_index, element_value, query_position
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_column, out_value
    logic [1:0]  m_tuser;   // region
    logic        m_tlast;
    logic        cfg_wen;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    clti_scoreboard sb;
    bit             tx_idle;
    bit             rx_idle;
    int             beats_seen;

    clamped_linear_table_interpolator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offers one input beat after a random gap and waits for its acceptance.
    task send_item(logic op, logic [7:0] row, logic [4:0] col,
                   logic [31:0] val, logic [31:0] pos);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pos, val, col, row};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        sb.note_input(op, row, col, val, pos);
    endtask

    // Register writes happen only while the block is drained.
    task write_register(logic idx, logic [8:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        sb.set_register(idx, 32'(data));
        @(posedge clk);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Loads rows with ascending positions and random data columns.
    task fill_table(int nrows, int ncols);
        longint posn;
        posn = -64'sd2147483648 + longint'($urandom % 32'h7000_0000);
        for (int r = 0; r < nrows; r++)
        begin
            posn += $urandom_range(1, 1 << 20);
            for (int c = 0; c < ncols; c++)
                send_item(OP_WRITE, 8'(r), 5'(c), (c == 0) ? posn[31:0] : $urandom,
                          $urandom);
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial
    begin
        int    stall;
        beat_t got;
        m_tready   <= 1'b0;
        beats_seen = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (beats_seen == 30)
                stall = 400;
            else
                stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            got.col    = m_tdata[4:0];
            got.value  = m_tdata[36:5];
            got.region = m_tuser;
            got.last   = m_tlast;
            @(posedge clk);
            sb.check_beat(got);
            beats_seen++;
        end
    end

    initial
    begin
        #50000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Main stimulus: directed cases, then random phases over several settings.
    initial
    begin
        int          nrows, ncols, r;
        logic [31:0] pos;
        int          row_set [5];
        int          col_set [5];
        sb        = new();
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WRITE;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single row, both counts zero: at or before is low, past is high.
        write_register(CFG_ROW_COUNT, 9'd0);
        write_register(CFG_COLUMN_COUNT, 9'd0);
        send_item(OP_WRITE, 8'd0, 5'd0, 32'h0000_0000, 32'h0);
        send_item(OP_QUERY, 8'hFF, 5'h1F, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(OP_QUERY, 8'h00, 5'h00, 32'h0, 32'h0000_0000);
        send_item(OP_QUERY, 8'h00, 5'h00, 32'h0, 32'h0000_0001);
        send_item(OP_QUERY, 8'h00, 5'h00, 32'h0, 32'h7FFF_FFFF);
        wait_drained();

        // Three rows spanning the full position range with extreme values.
        write_register(CFG_ROW_COUNT, 9'd3);
        write_register(CFG_COLUMN_COUNT, 9'd4);
        for (int rr = 0; rr < 3; rr++)
            for (int c = 0; c < 4; c++)
                send_item(OP_WRITE, 8'(rr), 5'(c),
                          (c == 0) ? ((rr == 0) ? 32'h8000_0000 :
                                      (rr == 1) ? 32'h0 : 32'h7FFF_FFFE) :
                          (((rr + c) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000), 32'h0);
        send_item(OP_QUERY, 8'h0, 5'h0, 32'h0, 32'h8000_0000);
        send_item(OP_QUERY, 8'h0, 5'h0, 32'h0, 32'hFFFF_FFFB);
        send_item(OP_QUERY, 8'h0, 5'h0, 32'h0, 32'h0000_0000);
        send_item(OP_QUERY, 8'h0, 5'h0, 32'h0, 32'h0000_0001);
        send_item(OP_QUERY, 8'h0, 5'h0, 32'h0, 32'h7FFF_FFFE);
        send_item(OP_QUERY, 8'h0, 5'h0, 32'h0, 32'h7FFF_FFFF);
        wait_drained();

        // Random phases; a column count above range saturates. After the fill,
        // each phase sends a query first so the long hold-off backs up the input.
        row_set = '{1, 8, 4, 2, 3};
        col_set = '{63, 3, 4, 2, 1};
        for (int ph = 0; ph < 5; ph++)
        begin
            tx_idle = (ph % 2 == 0);
            rx_idle = (ph != 3);
            write_register(CFG_ROW_COUNT, 9'(row_set[ph]));
            write_register(CFG_COLUMN_COUNT, 9'(col_set[ph]));
            nrows = (row_set[ph] > 256) ? 256 : row_set[ph];
            ncols = (col_set[ph] > 32) ? 32 : col_set[ph];
            fill_table(nrows, ncols);
            for (int i = 0; i < 7; i++)
            begin
                r = $urandom_range(0, nrows - 1);
                if (i > 0 && $urandom_range(0, 4) == 0)
                    send_item(OP_WRITE, 8'(r), 5'($urandom_range(0, ncols - 1)),
                              $urandom, $urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0, 1: pos = $urandom;
                        2:    pos = sb.tbl[r][0];
                        default: pos = sb.tbl[r][0] + $urandom_range(0, 64) - 32;
                    endcase
                    send_item(OP_QUERY, 8'($urandom), 5'($urandom), $urandom, pos);
                end
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/clti_pkg.sv
src/clti_fifo.sv
src/clti_front.sv
src/clti_div.sv
src/clti_back.sv
src/clamped_linear_table_interpolator.sv
tb/tb_top.sv
